@@ rtl/core/bft_pkg.sv @@
// Shared types and constants of the breadth-first traversal unit.
package bft_pkg;

   // Width of a vertex index and of one adjacency row as they appear on the ports.
   localparam int VERT_W = 4;
   localparam int ROW_W = 16;
   // Largest number of vertices that the port widths can address.
   localparam int VERT_COUNT_MAX = 16;

   // What the back end is to do with a word.
   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_STORE_RUN,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [VERT_W-1:0]     index;
      logic                  present;
      logic [ROW_W-1:0]      bits;
   } cmd_type;

endpackage

@@ rtl/core/bft_front.sv @@
// Input stage: takes row words, classifies them and hands commands to the queue.
module bft_front #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bft_pkg::VERT_W-1:0]    row_index,
   input  logic                          vertex_present,
   input  logic [bft_pkg::ROW_W-1:0]     row_bits,
   input  logic                          last_row,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output bft_pkg::cmd_type              cmd
);
   import bft_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    in_range;
   logic    keep;
   logic    accept;

   // A row outside the graph is dropped unless it carries the last mark.
   assign in_range = 32'(row_index) < MAX_VERTICES;
   assign keep = in_range || last_row;

   assign cmd_valid = hold_valid_ff;
   assign cmd = hold_cmd_ff;
   assign req_ready = !hold_valid_ff || cmd_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in = hold_cmd_ff;
      if (hold_valid_ff && cmd_ready) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = keep;
         hold_cmd_in.index = row_index;
         hold_cmd_in.present = vertex_present;
         hold_cmd_in.bits = row_bits;
         if (!last_row) begin
            hold_cmd_in.kind = CMD_STORE;
         end else if (in_range) begin
            hold_cmd_in.kind = CMD_STORE_RUN;
         end else begin
            hold_cmd_in.kind = CMD_RUN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

@@ rtl/core/bft_cmd_fifo.sv @@
// Two-entry command queue between the input stage and the traversal engine.
module bft_cmd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  bft_pkg::cmd_type    push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output bft_pkg::cmd_type    pop_cmd
);
   import bft_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/bft_back.sv @@
// Traversal engine: holds the graph, runs the breadth-first walks and drives results.
module bft_back #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  bft_pkg::cmd_type              cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bft_pkg::VERT_W-1:0]    rsp_vertex,
   output logic                          rsp_comp_end,
   output logic                          rsp_run_end
);
   import bft_pkg::*;

   localparam int NUM_V = (MAX_VERTICES < VERT_COUNT_MAX) ? MAX_VERTICES : VERT_COUNT_MAX;
   localparam int IDX_W = $clog2(NUM_V);
   localparam int PTR_W = $clog2(NUM_V + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_POP,
      ST_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [NUM_V-1:0]   adj_ff [NUM_V];
   logic [NUM_V-1:0]   present_ff, present_in;
   logic [NUM_V-1:0]   visited_ff, visited_in;
   logic [IDX_W-1:0]   queue_ff [NUM_V];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [PTR_W-1:0]   seed_ff, seed_in;
   logic [NUM_V-1:0]   mask_ff, mask_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]   pend_vert_ff, pend_vert_in;
   logic               pend_comp_ff, pend_comp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VERT_W-1:0]  rsp_vert_ff, rsp_vert_in;
   logic               rsp_comp_ff, rsp_comp_in;
   logic               rsp_run_ff, rsp_run_in;

   logic               out_free;
   logic               adj_we;
   logic [IDX_W-1:0]   adj_waddr;
   logic               queue_we;
   logic [IDX_W-1:0]   queue_waddr;
   logic [IDX_W-1:0]   emit_vert;
   logic               emit;
   logic               flush_run;
   logic [IDX_W-1:0]   seed_idx;
   logic [IDX_W-1:0]   head_vert;
   logic [IDX_W-1:0]   low_idx;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vertex = rsp_vert_ff;
   assign rsp_comp_end = rsp_comp_ff;
   assign rsp_run_end = rsp_run_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign adj_waddr = cmd.index[IDX_W-1:0];
   assign seed_idx = seed_ff[IDX_W-1:0];
   assign head_vert = queue_ff[head_ff[IDX_W-1:0]];

   // Lowest neighbour still to be visited.
   always_comb begin
      low_idx = '0;
      for (int i = NUM_V - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      present_in = present_ff;
      visited_in = visited_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      seed_in = seed_ff;
      mask_in = mask_ff;
      pend_valid_in = pend_valid_ff;
      pend_vert_in = pend_vert_ff;
      pend_comp_in = pend_comp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vert_in = rsp_vert_ff;
      rsp_comp_in = rsp_comp_ff;
      rsp_run_in = rsp_run_ff;
      cmd_ready = 1'b0;
      adj_we = 1'b0;
      emit = 1'b0;
      emit_vert = '0;
      flush_run = 1'b0;
      queue_waddr = tail_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.kind == CMD_STORE || cmd.kind == CMD_STORE_RUN) begin
                  adj_we = 1'b1;
                  present_in[adj_waddr] = cmd.present;
               end
               if (cmd.kind == CMD_STORE_RUN || cmd.kind == CMD_RUN) begin
                  visited_in = '0;
                  seed_in = '0;
                  state_in = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            if (out_free) begin
               if (seed_ff == PTR_W'(NUM_V)) begin
                  // The vertex held back is the last of the run.
                  flush_run = pend_valid_ff;
                  state_in = ST_IDLE;
               end else begin
                  seed_in = seed_ff + 1'b1;
                  if (present_ff[seed_idx] && !visited_ff[seed_idx]) begin
                     emit = 1'b1;
                     emit_vert = seed_idx;
                     queue_waddr = '0;
                     head_in = '0;
                     tail_in = PTR_W'(1);
                     state_in = ST_POP;
                  end
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               if (head_ff == tail_ff) begin
                  pend_comp_in = 1'b1;
                  state_in = ST_SEED;
               end else begin
                  head_in = head_ff + 1'b1;
                  mask_in = adj_ff[head_vert] & ~visited_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (mask_ff == '0) begin
                  state_in = ST_POP;
               end else begin
                  emit = 1'b1;
                  emit_vert = low_idx;
                  mask_in[low_idx] = 1'b0;
                  tail_in = tail_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The most recent vertex is held back so that its end flags are known when it leaves.
      if (emit) begin
         visited_in[emit_vert] = 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_vert_in = VERT_W'(pend_vert_ff);
            rsp_comp_in = pend_comp_ff;
            rsp_run_in = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_vert_in = emit_vert;
         pend_comp_in = 1'b0;
      end
      if (flush_run) begin
         rsp_valid_in = 1'b1;
         rsp_vert_in = VERT_W'(pend_vert_ff);
         rsp_comp_in = pend_comp_ff;
         rsp_run_in = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   assign queue_we = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         present_ff <= '0;
         visited_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         seed_ff <= '0;
         pend_valid_ff <= 1'b0;
         pend_comp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_V; i++) begin
            adj_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         present_ff <= present_in;
         visited_ff <= visited_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         seed_ff <= seed_in;
         pend_valid_ff <= pend_valid_in;
         pend_comp_ff <= pend_comp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adj_we) begin
            adj_ff[adj_waddr] <= cmd.bits[NUM_V-1:0];
         end
      end
      mask_ff <= mask_in;
      pend_vert_ff <= pend_vert_in;
      rsp_vert_ff <= rsp_vert_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_run_ff <= rsp_run_in;
      if (queue_we) begin
         queue_ff[queue_waddr] <= emit_vert;
      end
   end

   // Nothing is held back between runs.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held-back vertex left over outside a run");

   // The read pointer never passes the write pointer.
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff && tail_ff <= PTR_W'(NUM_V))
      else $error("visit queue pointers out of order");

   // Neighbours still to be emitted are never already visited.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (mask_ff & visited_ff) == '0)
      else $error("neighbour mask holds a visited vertex");

   // The run-end word goes out and the engine returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      flush_run |=> rsp_valid_ff && rsp_run_ff && state_ff == ST_IDLE)
      else $error("run end not delivered");

   // A new vertex only pushes a word out while the output stage can take it.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("vertex emitted into a full output stage");

endmodule

@@ rtl/core/breadth_first_traversal_unit.sv @@
// Top level of the breadth-first traversal unit over an adjacency matrix.
//
// Usage. Adjacency rows arrive on the req_ stream, one word per row: tdata carries
// the row index, the presence bit of that vertex and one edge bit per column;
// tlast marks the final row. Every row in range is stored, and the row marked last then
// starts a traversal of the stored graph. Results leave on the rsp_ stream, one
// word per visited vertex in breadth-first order: tdata holds the vertex index,
// tuser is set on the last vertex of one connected walk and tlast on the last
// vertex of the run. A run over a graph with no present vertex gives no word.
//
// Timing. Rows are taken one per cycle while the engine is idle and the queue has room; a
// row passes the input register and the command queue before it reaches the graph store.
// A traversal starts, steps through every seed position, dequeues each visited vertex, emits
// each neighbour found and closes each walk (MAX_VERTICES capped at 16), one step at a time
// in bft_back. Rows that arrive meanwhile wait in the input register and the queue.
//
// Reset clears the stored graph, the presence marks and all handshake state. When
// the receiver holds rsp_tready low the engine pauses in place and the result
// word holds; the input keeps filling the queue until it is full.
module breadth_first_traversal_unit #(
   parameter int MAX_VERTICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row_index [3:0], vertex_present [4], row_bits [20:5], zero fill
   input  logic        req_tlast,   // last_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // visited_vertex [3:0], zero fill
   output logic        rsp_tuser,   // component_end
   output logic        rsp_tlast    // run_end
);
   import bft_pkg::*;

   logic              front_valid;
   logic              front_ready;
   cmd_type           front_cmd;
   logic              queue_valid;
   logic              queue_ready;
   cmd_type           queue_cmd;
   logic [VERT_W-1:0] rsp_vertex;

   // The front classifies each row: store only, store and start a run, or start a
   // run alone for an out-of-range row that carries the last mark.
   bft_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .row_index      (req_tdata[3:0]),
      .vertex_present (req_tdata[4]),
      .row_bits       (req_tdata[20:5]),
      .last_row       (req_tlast),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   // The queue lets rows keep arriving while a traversal is under way.
   bft_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   // The back end owns the graph and the walk, and registers every result word.
   bft_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (queue_valid),
      .cmd_ready    (queue_ready),
      .cmd          (queue_cmd),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_vertex   (rsp_vertex),
      .rsp_comp_end (rsp_tuser),
      .rsp_run_end  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_vertex};

endmodule
